// ===== src/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types and constants of the serial mux frame deframer
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int SEG_W      = 11;
    localparam int REM_W      = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hBF;
    localparam logic [BYTE_W-1:0] NO_LINK   = 8'hFF;
    localparam logic [BYTE_W-1:0] MAX_LINK  = 8'd8;
    localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;

    localparam logic [SEG_W-1:0] SEG_CAP  = 11'd1024;
    localparam logic [SEG_W-1:0] SEG_ONE  = 11'd1;
    localparam logic [15:0]      LENGTH_LIMIT = 16'd1023;

    // register index, taken from paddr above the byte lanes
    localparam logic REG_MAX_SEGMENT = 1'b0;

    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_LINK,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_SYNC,
        PH_WAIT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FRAMING = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_ERROR   = 2'd2
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t        byte_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] link_id;
        logic              segment_last;
        logic              mux_mode;
    } mfd_result_t;

    typedef struct packed {
        phase_t phase;
        logic   remaining_zero;
    } mfd_status_t;

endpackage

// ===== src/mfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_parser
// frame parser state and the per-byte decode of one received byte
// ----------------------------------------------------------------------------
module mfd_parser
    import mfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [SEG_W-1:0]  max_segment,
    output mfd_result_t       result,
    output mfd_status_t       status
);

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  current_link_reg, current_link_next;
    logic [BYTE_W-1:0]  length_high_reg, length_high_next;
    logic [REM_W-1:0]   bytes_remaining_reg, bytes_remaining_next;
    logic [SEG_W-1:0]   segment_count_reg, segment_count_next;

    logic [SEG_W-1:0]   seg_limit;
    logic [SEG_W-1:0]   seg_inc;
    logic [REM_W-1:0]   rem_dec;
    logic [15:0]        frame_len;
    logic               link_bad;

    // out-of-range segment sizes are clamped
    always_comb begin
        if (max_segment == '0) begin
            seg_limit = SEG_ONE;
        end else if (max_segment > SEG_CAP) begin
            seg_limit = SEG_CAP;
        end else begin
            seg_limit = max_segment;
        end
    end

    assign seg_inc   = segment_count_reg + SEG_ONE;
    assign rem_dec   = (bytes_remaining_reg != '0) ? bytes_remaining_reg - 1'b1
                                                   : bytes_remaining_reg;
    assign frame_len = {length_high_reg, rx_byte};
    assign link_bad  = (current_link_reg > MAX_LINK) && (current_link_reg != NO_LINK);

    always_comb begin
        phase_next           = phase_reg;
        current_link_next    = current_link_reg;
        length_high_next     = length_high_reg;
        bytes_remaining_next = bytes_remaining_reg;
        segment_count_next   = segment_count_reg;
        result               = '0;
        result.byte_kind     = KIND_FRAMING;

        unique case (phase_reg)
            PH_PLAIN: begin
                if (rx_byte == SYNC_BYTE) begin
                    segment_count_next = '0;
                    phase_next         = PH_LINK;
                end else begin
                    result.byte_kind   = KIND_DATA;
                    result.data_byte   = rx_byte;
                    result.link_id     = NO_LINK;
                    segment_count_next = seg_inc;
                    if (seg_inc >= seg_limit || rx_byte == NEWLINE) begin
                        result.segment_last = 1'b1;
                        segment_count_next  = '0;
                    end
                end
            end
            PH_LINK: begin
                current_link_next = rx_byte;
                phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_high_next = rx_byte;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (link_bad || frame_len > LENGTH_LIMIT) begin
                    result.byte_kind = KIND_ERROR;
                    phase_next       = PH_WAIT;
                end else begin
                    bytes_remaining_next = frame_len[REM_W-1:0];
                    segment_count_next   = '0;
                    phase_next = (frame_len[REM_W-1:0] == '0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                result.byte_kind     = KIND_DATA;
                result.data_byte     = rx_byte;
                result.link_id       = current_link_reg;
                segment_count_next   = seg_inc;
                bytes_remaining_next = rem_dec;
                if (seg_inc >= seg_limit || rem_dec == '0) begin
                    result.segment_last = 1'b1;
                    segment_count_next  = '0;
                end
                if (rem_dec == '0) begin
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                if (rx_byte == ~current_link_reg) begin
                    phase_next = PH_SYNC;
                end else begin
                    result.byte_kind = KIND_ERROR;
                    phase_next       = PH_WAIT;
                end
            end
            PH_SYNC: begin
                if (rx_byte == SYNC_BYTE) begin
                    phase_next = PH_LINK;
                end else begin
                    result.byte_kind = KIND_ERROR;
                    phase_next       = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (rx_byte == SYNC_BYTE) begin
                    phase_next = PH_LINK;
                end
            end
        endcase

        result.mux_mode = (phase_next != PH_PLAIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_PLAIN;
            current_link_reg    <= NO_LINK;
            length_high_reg     <= '0;
            bytes_remaining_reg <= '0;
            segment_count_reg   <= '0;
        end else if (step_en) begin
            phase_reg           <= phase_next;
            current_link_reg    <= current_link_next;
            length_high_reg     <= length_high_next;
            bytes_remaining_reg <= bytes_remaining_next;
            segment_count_reg   <= segment_count_next;
        end
    end

    assign status.phase          = phase_reg;
    assign status.remaining_zero = (bytes_remaining_reg == '0);

endmodule

// ===== src/mfd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_out_stage
// result register on the master side of the deframer
// ----------------------------------------------------------------------------
module mfd_out_stage
    import mfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  mfd_result_t result_in,
    input  logic        m_tready,
    output logic        m_tvalid,
    output mfd_result_t result_out
);

    logic        valid_reg;
    mfd_result_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== src/mux_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mux_frame_deframer
// byte-at-a-time deframer for a serial line carrying plain text or mux frames
// ----------------------------------------------------------------------------
// channel   direction  ports                    contents
// s_        in         s_tvalid/tready/tdata    one received byte
// m_        out        m_tvalid/tready/tdata    one result per byte
//                      m_tlast, m_tuser
// apb       in/out     psel..prdata             max_segment at byte addr 0
//
// one byte per cycle sustained while the master side takes each result; each
// byte passes through the input register and then the result register
// the parser state advances when the input register hands its byte to the
// result register, so throughput is set by the combinational decode step
// synchronous active-low reset: plain mode, link 255, max_segment 1024
// a stalled master side holds the result register; the input register still
// takes one more byte, then s_tready drops until the result is taken
// ----------------------------------------------------------------------------
module mux_frame_deframer
    import mfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // receive byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte

    // deframed results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] data_byte, [15:8] link_id
    output logic                  m_tlast,   // segment_last
    output logic [2:0]            m_tuser,   // [1:0] byte_kind, [2] mux_mode

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration register
    logic [SEG_W-1:0] max_segment_reg;
    logic             cfg_write;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] rx_byte_reg;

    logic        advance;
    logic        s_accept;
    logic        out_valid;
    mfd_result_t step_result;
    mfd_result_t out_result;
    mfd_status_t parser_status;

    // ---------------- apb ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[CFG_ADDR_W-1] == REG_MAX_SEGMENT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_segment_reg <= SEG_CAP;
        end else if (cfg_write) begin
            max_segment_reg <= pwdata[SEG_W-1:0];
        end
    end

    // only one register; other words read as zero
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_MAX_SEGMENT)
                    ? {{(CFG_DATA_W-SEG_W){1'b0}}, max_segment_reg} : '0;

    // ---------------- input register ----------------
    // the held byte moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rx_byte_reg <= s_tdata;
        end
    end

    // ---------------- decode step ----------------
    mfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .rx_byte     (rx_byte_reg),
        .max_segment (max_segment_reg),
        .result      (step_result),
        .status      (parser_status)
    );

    // ---------------- result register ----------------
    mfd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (step_result),
        .m_tready   (m_tready),
        .m_tvalid   (out_valid),
        .result_out (out_result)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_result.link_id, out_result.data_byte};
    assign m_tlast  = out_result.segment_last;
    assign m_tuser  = {out_result.mux_mode, out_result.byte_kind};

    // ---------------- assertions ----------------
    // a segment end only ever marks a data byte
    a_last_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[1:0] == KIND_DATA))
        else $error("segment end on a non-data transaction");

    // plain-mode data always travels on the no-link id
    a_plain_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == KIND_DATA && !m_tuser[2]) |-> (m_tdata[15:8] == NO_LINK))
        else $error("plain data with a link id other than 255");

    // once in mux mode the parser never returns to plain mode
    a_mux_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (parser_status.phase != PH_PLAIN) |=> (parser_status.phase != PH_PLAIN))
        else $error("parser fell back to plain mode");

    // the payload phase always has bytes left to take
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (parser_status.phase == PH_PAYLOAD) |-> !parser_status.remaining_zero)
        else $error("payload phase with no bytes remaining");

endmodule
